// ===== hdl/bpa_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package bpa_pkg;

	// Port field widths
	localparam int PAGE_NUM_W = 12;
	localparam int PAGE_CNT_W = 13;
	localparam int TOTAL_W    = 13;

	// Internal page position: holds page_number + page_count and the limit
	localparam int POS_W = 14;

	// Bitmap word
	localparam int WORD_BITS = 64;
	localparam int OFF_W     = 6;

	// Default bitmap size in pages
	localparam int MAX_PAGES_DEF = 4096;

	// Highest page count the config register can express
	localparam int TOTAL_MAX = 8191;

	// Request actions
	localparam logic ACT_ALLOC = 1'b0;
	localparam logic ACT_FREE  = 1'b1;

	// Result status
	localparam logic STAT_OK  = 1'b0;
	localparam logic STAT_OOM = 1'b1;

endpackage

`default_nettype wire

// ===== hdl/bitmap_page_allocator.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel  Direction  Handshake              Payload
// in       input      in_valid / in_ready    action, page_number, page_count
// out      output     out_valid / out_ready  status, first_page
// cfg      input      cfg_we (no wait)       cfg_wdata -> total_pages
//
// Allocate: scans 64-page bitmap words from the search pointer, restarting past each used
// page met inside the scanned span, then writes every word the run touches and hands off
// through the done state. Free: writes every word the run touches, then hands off.
// All bitmap traffic goes through one read and one write port of the word memory.
// After reset a fill pass writes every word to all used, with in_ready low. A finished
// result waits in the output register; the next request is taken meanwhile, and the block
// holds its result until the output register frees up.

module bitmap_page_allocator
	import bpa_pkg::*;
#(
	parameter int MAX_PAGES = MAX_PAGES_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,

	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic                  action,
	input  wire logic [PAGE_NUM_W-1:0] page_number,
	input  wire logic [PAGE_CNT_W-1:0] page_count,

	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic                       status,
	output logic [TOTAL_W-1:0]         first_page,

	input  wire logic                  cfg_we,
	input  wire logic [TOTAL_W-1:0]    cfg_wdata
);

	localparam int WORDS   = (MAX_PAGES + WORD_BITS - 1) / WORD_BITS;
	localparam int AW      = (WORDS > 1) ? $clog2(WORDS) : 1;
	localparam int CLR_W   = $clog2(WORDS + 1);
	localparam int LIM_CAP = (MAX_PAGES > TOTAL_MAX) ? TOTAL_MAX : MAX_PAGES;

	localparam logic [2:0] ST_CLR  = 3'd0;
	localparam logic [2:0] ST_IDLE = 3'd1;
	localparam logic [2:0] ST_SCAN = 3'd2;
	localparam logic [2:0] ST_FILL = 3'd3;
	localparam logic [2:0] ST_DONE = 3'd4;

	typedef logic [WORD_BITS-1:0] word_t;
	typedef logic [POS_W-1:0]     pos_t;

	// Control state
	logic [2:0]         state_q, state_d;
	logic [CLR_W-1:0]   clr_q;
	logic [TOTAL_W-1:0] total_q;
	logic [TOTAL_W-1:0] ss_q, ss_d;
	logic               out_valid_q;

	// Working registers
	pos_t               pos_q, pos_d;
	pos_t               cand_q, cand_d;
	pos_t               end_q, end_d;
	logic [PAGE_CNT_W-1:0] cnt_q, cnt_d;
	logic               set_q, set_d;
	logic               res_stat_q, res_stat_d;
	logic [TOTAL_W-1:0] res_first_q, res_first_d;
	logic               status_q;
	logic [TOTAL_W-1:0] first_q;

	// Bitmap memory
	word_t              mem [WORDS];
	word_t              rdata_q;
	logic [AW-1:0]      rd_addr, wr_addr;
	logic               mem_we;
	word_t              mem_wdata;

	// Effective page limit
	logic [TOTAL_W-1:0] lim;
	pos_t               lim_p;
	assign lim   = (total_q > TOTAL_W'(LIM_CAP)) ? TOTAL_W'(LIM_CAP) : total_q;
	assign lim_p = {1'b0, lim};

	// Word view of the current position
	pos_t               wbase;
	logic [OFF_W-1:0]   off;
	word_t              lo_mask;
	assign wbase   = {pos_q[POS_W-1:OFF_W], {OFF_W{1'b0}}};
	assign off     = pos_q[OFF_W-1:0];
	assign lo_mask = {WORD_BITS{1'b1}} << off;

	// Lowest used page at or above the position
	word_t              used_m;
	logic               found;
	logic [OFF_W-1:0]   u;
	assign used_m = rdata_q & lo_mask;

	always_comb begin
		found = 1'b0;
		u     = '0;
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			if (used_m[i]) begin
				found = 1'b1;
				u     = OFF_W'(i);
			end
		end
	end

	// End of the free span reachable in this word
	pos_t ue, span_end, need_end, next_word;
	assign next_word = wbase + POS_W'(WORD_BITS);
	assign ue        = found ? (wbase + {{(POS_W - OFF_W){1'b0}}, u}) : next_word;
	assign span_end  = (ue < lim_p) ? ue : lim_p;
	assign need_end  = cand_q + {1'b0, cnt_q};

	// Fill mask for the run inside this word
	pos_t  rel;
	word_t hi_mask, fill_mask;
	assign rel       = end_q - wbase;
	assign hi_mask   = (rel >= POS_W'(WORD_BITS)) ? {WORD_BITS{1'b1}}
		: ((word_t'(1) << rel[OFF_W-1:0]) - word_t'(1));
	assign fill_mask = lo_mask & hi_mask;

	// Free request range
	pos_t free_sum, free_end;
	assign free_sum = {2'b0, page_number} + {1'b0, page_count};
	assign free_end = (free_sum < lim_p) ? free_sum : lim_p;

	assign in_ready = (state_q == ST_IDLE);

	// Sequencer
	always_comb begin
		state_d     = state_q;
		pos_d       = pos_q;
		cand_d      = cand_q;
		end_d       = end_q;
		cnt_d       = cnt_q;
		set_d       = set_q;
		ss_d        = ss_q;
		res_stat_d  = res_stat_q;
		res_first_d = res_first_q;
		mem_we      = 1'b0;
		mem_wdata   = {WORD_BITS{1'b1}};
		wr_addr     = AW'(32'(pos_q[POS_W-1:OFF_W]));

		unique case (state_q)
			ST_CLR: begin
				mem_we  = 1'b1;
				wr_addr = clr_q[AW-1:0];
				if (clr_q == CLR_W'(WORDS - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_valid) begin
					if (action == ACT_FREE) begin
						ss_d        = {1'b0, page_number};
						res_stat_d  = STAT_OK;
						res_first_d = {1'b0, page_number};
						pos_d       = {2'b0, page_number};
						end_d       = free_end;
						set_d       = 1'b0;
						state_d     = ({2'b0, page_number} < free_end) ? ST_FILL : ST_DONE;
					end else if (page_count == '0) begin
						res_stat_d  = STAT_OK;
						res_first_d = ss_q;
						state_d     = ST_DONE;
					end else if (ss_q >= lim) begin
						ss_d        = lim;
						res_stat_d  = STAT_OOM;
						res_first_d = '0;
						state_d     = ST_DONE;
					end else begin
						pos_d   = {1'b0, ss_q};
						cand_d  = {1'b0, ss_q};
						cnt_d   = page_count;
						state_d = ST_SCAN;
					end
				end
			end
			ST_SCAN: begin
				if (pos_q >= lim_p || (need_end > span_end && span_end >= lim_p)) begin
					// no run before the limit
					ss_d        = lim;
					res_stat_d  = STAT_OOM;
					res_first_d = '0;
					state_d     = ST_DONE;
				end else if (need_end <= span_end) begin
					// run fits: mark it used
					ss_d        = TOTAL_W'(need_end);
					res_stat_d  = STAT_OK;
					res_first_d = TOTAL_W'(cand_q);
					pos_d       = cand_q;
					end_d       = need_end;
					set_d       = 1'b1;
					state_d     = ST_FILL;
				end else if (found) begin
					// used page breaks the run: restart past it
					pos_d  = ue + POS_W'(1);
					cand_d = ue + POS_W'(1);
				end else begin
					pos_d = next_word;
				end
			end
			ST_FILL: begin
				mem_we    = 1'b1;
				mem_wdata = set_q ? (rdata_q | fill_mask) : (rdata_q & ~fill_mask);
				pos_d     = next_word;
				if (next_word >= end_q) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Read address tracks the next position so data lines up with pos_q
	assign rd_addr = AW'(32'(pos_d[POS_W-1:OFF_W]));

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[wr_addr] <= mem_wdata;
		end
		rdata_q <= mem[rd_addr];
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLR;
			clr_q       <= '0;
			total_q     <= TOTAL_W'(MAX_PAGES_DEF);
			ss_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			ss_q    <= ss_d;
			if (state_q == ST_CLR) begin
				clr_q <= clr_q + CLR_W'(1);
			end
			if (cfg_we) begin
				total_q <= cfg_wdata;
			end
			if (state_q == ST_DONE && (!out_valid_q || out_ready)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Working and result payload
	always_ff @(posedge clk) begin
		pos_q       <= pos_d;
		cand_q      <= cand_d;
		end_q       <= end_d;
		cnt_q       <= cnt_d;
		set_q       <= set_d;
		res_stat_q  <= res_stat_d;
		res_first_q <= res_first_d;
		if (state_q == ST_DONE && (!out_valid_q || out_ready)) begin
			status_q <= res_stat_q;
			first_q  <= res_first_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign status     = status_q;
	assign first_page = first_q;

endmodule

`default_nettype wire
